// ===== design/exlex_pkg.sv =====
// Shared types, codes and character helpers for the expression lexer.
`timescale 1ns / 1ps

package exlex_pkg;

   localparam int NUM_BITS       = 31;
   localparam int POS_BITS       = 16;
   localparam int QUEUE_DEPTH_DEF = 4;

   // Keyword "return": its length and the offset of its second 'r'.
   localparam logic [2:0] KW_LEN       = 3'd6;
   localparam logic [2:0] KW_REPEAT_AT = 3'd4;

   localparam logic [7:0] CHAR_TAB        = 8'h09;
   localparam logic [7:0] CHAR_CR         = 8'h0d;
   localparam logic [7:0] CHAR_SPACE      = 8'h20;
   localparam logic [7:0] CHAR_0          = 8'h30;
   localparam logic [7:0] CHAR_9          = 8'h39;
   localparam logic [7:0] CHAR_UPPER_A    = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z    = 8'h5a;
   localparam logic [7:0] CHAR_UNDERSCORE = 8'h5f;
   localparam logic [7:0] CHAR_LOWER_A    = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z    = 8'h7a;

   typedef enum logic [3:0] {
      KIND_NUM    = 4'd0,
      KIND_IDENT  = 4'd1,
      KIND_RETURN = 4'd2,
      KIND_END    = 4'd3,
      KIND_PLUS   = 4'd4,
      KIND_MINUS  = 4'd5,
      KIND_STAR   = 4'd6,
      KIND_SLASH  = 4'd7,
      KIND_LPAREN = 4'd8,
      KIND_RPAREN = 4'd9,
      KIND_SEMI   = 4'd10,
      KIND_ASSIGN = 4'd11,
      KIND_ERROR  = 4'd12
   } kind_type;

   typedef enum logic [1:0] {
      MODE_IDLE   = 2'd0,
      MODE_NUM    = 2'd1,
      MODE_PREFIX = 2'd2,
      MODE_ERR    = 2'd3
   } mode_type;

   typedef struct packed {
      logic [7:0] ch;
      logic       end_of_text;
   } req_type;

   typedef struct packed {
      kind_type              kind;
      logic [NUM_BITS-1:0]   value;
      logic [POS_BITS-1:0]   position;
      logic                  last;
   } rsp_type;

   // Token list for one byte: number, flushed keyword letters or return, one tail token.
   typedef struct packed {
      logic                  num_en;
      logic [NUM_BITS-1:0]   num_value;
      logic [POS_BITS-1:0]   start_pos;
      logic [2:0]            flush_cnt;
      logic                  ret_en;
      logic                  tail_en;
      kind_type              tail_kind;
      logic [4:0]            tail_value;
      logic [POS_BITS-1:0]   tail_pos;
   } job_type;

   typedef struct packed {
      logic full;
      logic not_empty;
   } qstat_type;

   function automatic logic [7:0] kw_char(input logic [2:0] idx);
      logic [7:0] c;
      unique case (idx)
         3'd0:    c = 8'h72;
         3'd1:    c = 8'h65;
         3'd2:    c = 8'h74;
         3'd3:    c = 8'h75;
         3'd4:    c = 8'h72;
         3'd5:    c = 8'h6e;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   function automatic logic [4:0] letter_index(input logic [7:0] c);
      logic [7:0] d;
      d = c - CHAR_LOWER_A;
      return d[4:0];
   endfunction

   // KIND_ERROR marks a byte that is no punctuator.
   function automatic kind_type punct_kind(input logic [7:0] c);
      kind_type k;
      unique case (c)
         8'h2b:   k = KIND_PLUS;
         8'h2d:   k = KIND_MINUS;
         8'h2a:   k = KIND_STAR;
         8'h2f:   k = KIND_SLASH;
         8'h28:   k = KIND_LPAREN;
         8'h29:   k = KIND_RPAREN;
         8'h3b:   k = KIND_SEMI;
         8'h3d:   k = KIND_ASSIGN;
         default: k = KIND_ERROR;
      endcase
      return k;
   endfunction

endpackage

// ===== design/exlex_front.sv =====
// Front end: accepts bytes, tracks lexer state and builds the token list for each byte.
`timescale 1ns / 1ps

module exlex_front
   import exlex_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      req_valid,
   output logic      req_ready,
   input  req_type   req_data,
   input  qstat_type q_stat,
   output logic      push,
   output job_type   push_job
);

   mode_type            mode_ff, mode_in;
   logic [NUM_BITS-1:0] acc_ff, acc_in;
   logic [2:0]          len_ff, len_in;
   logic [POS_BITS-1:0] pstart_ff, pstart_in;
   logic [POS_BITS-1:0] boff_ff, boff_in;

   logic                accept;
   logic [7:0]          ch;
   logic                eot;
   logic                is_digit, is_lower, is_word, is_space, is_punct, is_err;
   kind_type            pk;
   logic [2:0]          le;
   logic                kw_hit, ret_hit, split_hit, restart_r, process_c, active;
   logic [2:0]          flush;
   logic [NUM_BITS+3:0] acc_x10;
   logic                acc_sat;
   job_type             job;

   assign ch        = req_data.ch;
   assign eot       = req_data.end_of_text;
   assign req_ready = !q_stat.full;
   assign accept    = req_valid && req_ready;

   // Classify the byte and decide how the buffered keyword prefix resolves.
   always_comb begin
      is_digit  = (ch >= CHAR_0) && (ch <= CHAR_9);
      is_lower  = (ch >= CHAR_LOWER_A) && (ch <= CHAR_LOWER_Z);
      is_word   = is_digit || is_lower || (ch == CHAR_UNDERSCORE) ||
                  ((ch >= CHAR_UPPER_A) && (ch <= CHAR_UPPER_Z));
      is_space  = (ch == CHAR_SPACE) || ((ch >= CHAR_TAB) && (ch <= CHAR_CR));
      pk        = punct_kind(ch);
      is_punct  = (pk != KIND_ERROR);
      is_err    = !is_space && !is_punct && !is_digit && !is_lower;
      le        = (mode_ff == MODE_PREFIX) ? len_ff : 3'd0;
      kw_hit    = (le < KW_LEN) && (ch == kw_char(le));
      ret_hit   = (le == KW_LEN) && !is_word;
      // "retur" then 'e': the second 'r' starts a new prefix.
      split_hit = (le == KW_LEN - 3'd1) && (ch == kw_char(3'd1));
      restart_r = !kw_hit && (ch == kw_char(3'd0));
      process_c = !kw_hit && !split_hit && !restart_r;
      flush     = (kw_hit || ret_hit) ? 3'd0 : (split_hit ? KW_REPEAT_AT : le);
      active    = !eot && (mode_ff != MODE_ERR) && !((mode_ff == MODE_NUM) && is_digit);
      acc_x10   = {1'b0, acc_ff, 3'b000} + {3'b000, acc_ff, 1'b0} +
                  {{(NUM_BITS){1'b0}}, ch[3:0]};
      acc_sat   = |acc_x10[NUM_BITS+3:NUM_BITS];
   end

   // Next state.
   always_comb begin
      mode_in   = mode_ff;
      acc_in    = acc_ff;
      len_in    = len_ff;
      pstart_in = pstart_ff;
      boff_in   = boff_ff;
      if (accept) begin
         priority if (eot) begin
            mode_in   = MODE_IDLE;
            acc_in    = '0;
            len_in    = '0;
            pstart_in = '0;
            boff_in   = '0;
         end else if (mode_ff == MODE_ERR) begin
            boff_in = boff_ff + 1'b1;
         end else if ((mode_ff == MODE_NUM) && is_digit) begin
            boff_in = boff_ff + 1'b1;
            acc_in  = acc_sat ? {NUM_BITS{1'b1}} : acc_x10[NUM_BITS-1:0];
         end else begin
            boff_in = boff_ff + 1'b1;
            mode_in = MODE_IDLE;
            len_in  = '0;
            priority if (kw_hit) begin
               mode_in = MODE_PREFIX;
               len_in  = le + 3'd1;
               if (le == 3'd0) begin
                  pstart_in = boff_ff;
               end
            end else if (split_hit) begin
               mode_in   = MODE_PREFIX;
               len_in    = 3'd2;
               pstart_in = pstart_ff + POS_BITS'(KW_REPEAT_AT);
            end else if (restart_r) begin
               mode_in   = MODE_PREFIX;
               len_in    = 3'd1;
               pstart_in = boff_ff;
            end else if (is_digit) begin
               mode_in   = MODE_NUM;
               acc_in    = {{(NUM_BITS-4){1'b0}}, ch[3:0]};
               pstart_in = boff_ff;
            end else if (is_err) begin
               mode_in = MODE_ERR;
            end else begin
               mode_in = MODE_IDLE;
            end
         end
      end
   end

   // Token list for the accepted byte.
   always_comb begin
      job.num_en     = 1'b0;
      job.num_value  = acc_ff;
      job.start_pos  = pstart_ff;
      job.flush_cnt  = 3'd0;
      job.ret_en     = 1'b0;
      job.tail_en    = 1'b0;
      job.tail_kind  = KIND_END;
      job.tail_value = 5'd0;
      job.tail_pos   = boff_ff;
      if (eot) begin
         job.num_en  = (mode_ff == MODE_NUM);
         job.tail_en = 1'b1;
         if (mode_ff == MODE_PREFIX) begin
            if (len_ff == KW_LEN) begin
               job.ret_en = 1'b1;
            end else begin
               job.flush_cnt = len_ff;
            end
         end
      end else if (active) begin
         job.num_en    = (mode_ff == MODE_NUM);
         job.flush_cnt = flush;
         job.ret_en    = ret_hit;
         if (process_c) begin
            priority if (is_punct) begin
               job.tail_en   = 1'b1;
               job.tail_kind = pk;
            end else if (is_lower) begin
               job.tail_en    = 1'b1;
               job.tail_kind  = KIND_IDENT;
               job.tail_value = letter_index(ch);
            end else if (is_err) begin
               job.tail_en   = 1'b1;
               job.tail_kind = KIND_ERROR;
            end else begin
               job.tail_en = 1'b0;
            end
         end
      end
   end

   assign push_job = job;
   assign push     = accept &&
                     (job.num_en || job.ret_en || job.tail_en || (job.flush_cnt != 3'd0));

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_IDLE;
         acc_ff    <= '0;
         len_ff    <= '0;
         pstart_ff <= '0;
         boff_ff   <= '0;
      end else begin
         mode_ff   <= mode_in;
         acc_ff    <= acc_in;
         len_ff    <= len_in;
         pstart_ff <= pstart_in;
         boff_ff   <= boff_in;
      end
   end

endmodule

// ===== design/exlex_queue.sv =====
// Short queue of token lists between front and back end.
`timescale 1ns / 1ps

module exlex_queue
   import exlex_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEF
)(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  job_type   push_job,
   input  logic      pop,
   output qstat_type q_stat,
   output job_type   head_job
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   job_type          slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      unique case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   assign q_stat.full      = (count_ff == CNT_W'(DEPTH));
   assign q_stat.not_empty = (count_ff != '0);
   assign head_job         = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== design/exlex_back.sv =====
// Back end: moves a list's tokens to the output register, one a cycle unless stalled.
`timescale 1ns / 1ps

module exlex_back
   import exlex_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  qstat_type q_stat,
   input  job_type   head_job,
   output logic      pop,
   output logic      rsp_valid,
   input  logic      rsp_ready,
   output rsp_type   rsp_data
);

   logic [2:0] k_ff, k_in;
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_ff, rsp_in;

   logic [2:0] j;
   logic [3:0] n_tok;
   logic       tok_last;
   logic       load;

   assign load = q_stat.not_empty && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      j        = k_ff - {2'b00, head_job.num_en};
      n_tok    = {3'b000, head_job.num_en} + {1'b0, head_job.flush_cnt} +
                 {3'b000, head_job.ret_en} + {3'b000, head_job.tail_en};
      tok_last = ({1'b0, k_ff} == (n_tok - 4'd1));
      rsp_in.last = tok_last;
      priority if (head_job.num_en && (k_ff == 3'd0)) begin
         rsp_in.kind     = KIND_NUM;
         rsp_in.value    = head_job.num_value;
         rsp_in.position = head_job.start_pos;
      end else if (j < head_job.flush_cnt) begin
         rsp_in.kind     = KIND_IDENT;
         rsp_in.value    = NUM_BITS'(letter_index(kw_char(j)));
         rsp_in.position = head_job.start_pos + POS_BITS'(j);
      end else if (head_job.ret_en && (j == 3'd0)) begin
         rsp_in.kind     = KIND_RETURN;
         rsp_in.value    = '0;
         rsp_in.position = head_job.start_pos;
      end else begin
         rsp_in.kind     = head_job.tail_kind;
         rsp_in.value    = NUM_BITS'(head_job.tail_value);
         rsp_in.position = head_job.tail_pos;
      end
   end

   always_comb begin
      k_in         = k_ff;
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         k_in         = tok_last ? 3'd0 : k_ff + 3'd1;
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign pop       = load && tok_last;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         k_ff         <= k_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== design/expression_lexer_core.sv =====
// Top level of the expression lexer: front end, token-list queue, back end.
//
// Usage: source bytes arrive on the req_ channel (ch, end_of_text), one item
// per accepted handshake. Tokens leave on the rsp_ channel (kind, value,
// position, last); last marks the final token caused by one input item.
// The first token of a byte passes through the token-list queue into the output
// register and is offered from then on. The front takes one byte a cycle while
// the queue of QUEUE_DEPTH token lists has room; the back emits one token a
// cycle while the receiver takes them. One byte can flush up to seven tokens
// (when a buffered "return" turns into identifiers), and the back moves on to
// the next token list only after the last token of the current one.
// Bytes that cause no token (whitespace, digits inside a number, keyword
// letters being buffered, bytes after an error) never enter the queue.
// Reset (synchronous) clears lexer state, empties the queue and drops any
// token on the output; the next text starts at offset 0, as it also does
// after every end marker.
// When the receiver stalls, the output token holds, the queue fills and
// req_ready drops until room frees up.
`timescale 1ns / 1ps

module expression_lexer_core
   import exlex_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   qstat_type q_stat;
   logic      push;
   logic      pop;
   job_type   push_job;
   job_type   head_job;

   exlex_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_stat    (q_stat),
      .push      (push),
      .push_job  (push_job)
   );

   exlex_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .q_stat   (q_stat),
      .head_job (head_job)
   );

   exlex_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_stat    (q_stat),
      .head_job  (head_job),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== design/exlex_checker.sv =====
// Port-level checks on the expression lexer, bound to the top level.
`timescale 1ns / 1ps

module exlex_checker
   import exlex_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // A waiting byte stays offered with the same payload.
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_data))
      else $error("req item changed while waiting");

   // A stalled token stays offered.
   a_rsp_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp_valid dropped while stalled");

   // A stalled token keeps its payload.
   a_rsp_hold_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_data))
      else $error("rsp_data changed while stalled");

   // Reset drops any pending token.
   a_reset_clears_rsp: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("token offered right after reset");

   // Reset leaves the queue empty, so bytes are taken at once.
   a_reset_ready: assert property (@(posedge clock)
      reset |=> req_ready)
      else $error("req_ready low right after reset");

endmodule

bind expression_lexer_core exlex_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the expression lexer core.
`timescale 1ns / 1ps

module testbench
   import exlex_pkg::*;
();

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int TARGET_ITEMS = 450;
   localparam int MAX_TOKENS = 7;
   localparam int WORD_LEN = 6;
   localparam longint unsigned NUMBER_CAP = (64'd1 << NUM_BITS) - 1;
   localparam logic [0:5][7:0] KEYWORD = "return";
   localparam logic [0:7][7:0] PUNCTS = "+-*/()=;";
   localparam logic [0:17][7:0] ODD_CHARS = "!#$%&.,<>?@[]^{}|~";

   // Lexer state shadow plus the queue of tokens still to come out.
   class token_scoreboard;
      mode_type            mode;
      logic [NUM_BITS-1:0] number_acc;
      logic [2:0]          prefix_len;
      logic [POS_BITS-1:0] pending_start;
      logic [POS_BITS-1:0] byte_offset;
      rsp_type             expected_tokens[$];
      rsp_type             step_tokens[$];
      int                  failures;

      function new();
         clear();
         failures = 0;
      endfunction

      function void clear();
         mode = MODE_IDLE;
         number_acc = '0;
         prefix_len = '0;
         pending_start = '0;
         byte_offset = '0;
      endfunction

      function int pending();
         return expected_tokens.size();
      endfunction

      function bit is_digit(logic [7:0] c);
         return c >= "0" && c <= "9";
      endfunction

      function bit is_word_char(logic [7:0] c);
         return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || is_digit(c) || c == "_";
      endfunction

      function bit is_blank(logic [7:0] c);
         return c == " " || (c >= 8'd9 && c <= 8'd13);
      endfunction

      function bit punct_of(logic [7:0] c, output kind_type k);
         k = KIND_ERROR;
         case (c)
            "+": k = KIND_PLUS;
            "-": k = KIND_MINUS;
            "*": k = KIND_STAR;
            "/": k = KIND_SLASH;
            "(": k = KIND_LPAREN;
            ")": k = KIND_RPAREN;
            ";": k = KIND_SEMI;
            "=": k = KIND_ASSIGN;
            default: return 1'b0;
         endcase
         return 1'b1;
      endfunction

      function void add_token(kind_type k, logic [NUM_BITS-1:0] v, logic [POS_BITS-1:0] p);
         rsp_type t;
         if (step_tokens.size() >= MAX_TOKENS) return;
         t.kind = k;
         t.value = v;
         t.position = p;
         t.last = 1'b0;
         step_tokens.push_back(t);
      endfunction

      function bit word_match(logic [7:0] q[7], int start, int len);
         for (int k = 0; k < len; k++)
            if (q[start + k] != KEYWORD[k]) return 1'b0;
         return 1'b1;
      endfunction

      // Tokenize buffered bytes q[0..qlen), byte i sitting at offset base+i.
      function void rescan(logic [7:0] q[7], int qlen, logic [POS_BITS-1:0] base,
                           bit flush_pass);
         int                  i;
         int                  rem;
         logic [POS_BITS-1:0] pos;
         logic [7:0]          c;
         kind_type            pk;
         i = 0;
         mode = MODE_IDLE;
         prefix_len = '0;
         while (i < qlen) begin
            rem = qlen - i;
            pos = base + POS_BITS'(i);
            c = q[i];
            if (rem >= WORD_LEN && word_match(q, i, WORD_LEN)) begin
               if (rem > WORD_LEN ? !is_word_char(q[i + WORD_LEN]) : flush_pass) begin
                  add_token(KIND_RETURN, '0, pos);
                  i += WORD_LEN;
                  continue;
               end
               if (rem == WORD_LEN) begin
                  mode = MODE_PREFIX;
                  prefix_len = 3'(rem);
                  pending_start = pos;
                  return;
               end
            end else if (!flush_pass && rem < WORD_LEN && word_match(q, i, rem)) begin
               // hold a partial keyword until the next byte decides
               mode = MODE_PREFIX;
               prefix_len = 3'(rem);
               pending_start = pos;
               return;
            end
            if (is_blank(c)) begin
            end else if (punct_of(c, pk)) begin
               add_token(pk, '0, pos);
            end else if (is_digit(c)) begin
               mode = MODE_NUM;
               number_acc = NUM_BITS'(c - "0");
               pending_start = pos;
            end else if (c >= "a" && c <= "z") begin
               add_token(KIND_IDENT, NUM_BITS'(c - "a"), pos);
            end else begin
               add_token(KIND_ERROR, '0, pos);
               mode = MODE_ERR;
               return;
            end
            i++;
         end
      endfunction

      function void lex_item(req_type it);
         logic [7:0]          q[7];
         int                  qlen;
         logic [POS_BITS-1:0] base;
         longint unsigned     d;
         longint unsigned     acc;
         step_tokens = {};
         qlen = 0;
         base = byte_offset;
         if (it.end_of_text) begin
            if (mode == MODE_NUM) add_token(KIND_NUM, number_acc, pending_start);
            if (mode == MODE_PREFIX) begin
               for (int k = 0; k < prefix_len; k++) q[k] = KEYWORD[k];
               rescan(q, int'(prefix_len), pending_start, 1'b1);
            end
            add_token(KIND_END, '0, byte_offset);
            clear();
         end else if (mode == MODE_ERR) begin
            byte_offset++;
            return;
         end else begin
            if (mode == MODE_NUM) begin
               if (is_digit(it.ch)) begin
                  d = 64'(it.ch - "0");
                  acc = number_acc;
                  if (acc > (NUMBER_CAP - d) / 10) number_acc = NUM_BITS'(NUMBER_CAP);
                  else number_acc = NUM_BITS'(acc * 10 + d);
                  byte_offset++;
                  return;
               end
               add_token(KIND_NUM, number_acc, pending_start);
               mode = MODE_IDLE;
            end
            if (mode == MODE_PREFIX) begin
               for (int k = 0; k < prefix_len; k++) q[k] = KEYWORD[k];
               qlen = int'(prefix_len);
               base = pending_start;
            end
            q[qlen] = it.ch;
            qlen++;
            rescan(q, qlen, base, 1'b0);
            byte_offset++;
         end
         if (step_tokens.size() > 0) step_tokens[step_tokens.size() - 1].last = 1'b1;
         foreach (step_tokens[k]) expected_tokens.push_back(step_tokens[k]);
      endfunction

      function void check_token(rsp_type got);
         rsp_type want;
         if (expected_tokens.size() == 0) begin
            $error("token with none expected: kind %0d value %0d position %0d",
                   got.kind, got.value, got.position);
            failures++;
            return;
         end
         want = expected_tokens.pop_front();
         if (got.kind !== want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, got.kind);
            failures++;
         end
         if (got.value !== want.value) begin
            $error("value: expected %0d, got %0d", want.value, got.value);
            failures++;
         end
         if (got.position !== want.position) begin
            $error("position: expected %0d, got %0d", want.position, got.position);
            failures++;
         end
         if (got.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, got.last);
            failures++;
         end
      endfunction
   endclass

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   token_scoreboard lexer_sb;
   bit              send_idle = 1'b1;
   bit              sink_idle = 1'b1;
   int              items_sent = 0;
   int              quiet_cycles = 0;
   logic [7:0]      text_bytes[$];

   expression_lexer_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) lexer_sb.lex_item(req_data);
         if (rsp_valid && rsp_ready) lexer_sb.check_token(rsp_data);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("status: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Token sink: random stall before each item while sink_idle is set.
   initial begin
      int gap;
      forever begin
         gap = sink_idle ? $urandom_range(0, 6) : 0;
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (rsp_valid !== 1'b1);
      end
   end

   task automatic send_item(input req_type it);
      int gap;
      gap = send_idle ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= it;
      do @(posedge clock); while (req_ready !== 1'b1);
      items_sent++;
   endtask

   task automatic send_byte(input logic [7:0] c);
      req_type it;
      it.ch = c;
      it.end_of_text = 1'b0;
      send_item(it);
   endtask

   task automatic send_text(input string s);
      for (int k = 0; k < s.len(); k++) send_byte(s[k]);
   endtask

   task automatic send_end();
      req_type it;
      it.ch = 8'($urandom_range(0, 255));
      it.end_of_text = 1'b1;
      send_item(it);
   endtask

   // Drop valid and hold until every expected token is out.
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (lexer_sb.pending() != 0);
   endtask

   function automatic logic [7:0] any_lower();
      return "a" + 8'($urandom_range(0, 25));
   endfunction

   function automatic logic [7:0] any_blank();
      return $urandom_range(0, 1) ? " " : 8'(9 + $urandom_range(0, 4));
   endfunction

   // Mostly well-formed text with random content; a little noise.
   function automatic void compose_text();
      int  pieces;
      int  len;
      bit  nines;
      text_bytes = {};
      pieces = $urandom_range(0, 12);
      repeat (pieces) begin
         case ($urandom_range(0, 15))
            0, 1, 14: text_bytes.push_back(any_lower());
            2, 3: begin
               len = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 12) : $urandom_range(1, 4);
               nines = ($urandom_range(0, 2) == 0);
               repeat (len)
                  text_bytes.push_back(nines ? "9" : "0" + 8'($urandom_range(0, 9)));
            end
            4, 5, 13: text_bytes.push_back(PUNCTS[$urandom_range(0, 7)]);
            6, 7, 12: text_bytes.push_back(any_blank());
            8, 9, 10, 11: begin
               len = $urandom_range(0, 1) ? WORD_LEN : $urandom_range(1, WORD_LEN - 1);
               for (int k = 0; k < len; k++) text_bytes.push_back(KEYWORD[k]);
               case ($urandom_range(0, 7))
                  0: text_bytes.push_back(any_lower());
                  1: text_bytes.push_back("0" + 8'($urandom_range(0, 9)));
                  2: text_bytes.push_back($urandom_range(0, 1) ? "_" : "A" + 8'($urandom_range(0, 25)));
                  3: text_bytes.push_back(any_blank());
                  4: text_bytes.push_back(PUNCTS[$urandom_range(0, 7)]);
                  default: ;
               endcase
            end
            default: begin
               if ($urandom_range(0, 2) == 0) text_bytes.push_back(8'($urandom_range(0, 255)));
               else text_bytes.push_back(ODD_CHARS[$urandom_range(0, 17)]);
            end
         endcase
      end
   endfunction

   initial begin
      lexer_sb = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      send_text("+-*/()=;");
      // keyword followed by a letter turns back into identifiers
      send_text("returna");
      send_text("return");
      send_end();
      send_byte(8'h00);
      send_byte(8'hff);
      send_end();
      wait_drained();

      while (items_sent < TARGET_ITEMS) begin
         case ($urandom_range(0, 3))
            0: begin send_idle = 1'b1; sink_idle = 1'b1; end
            1: begin send_idle = 1'b0; sink_idle = 1'b0; end
            2: begin send_idle = 1'b1; sink_idle = 1'b0; end
            default: begin send_idle = 1'b0; sink_idle = 1'b1; end
         endcase
         compose_text();
         foreach (text_bytes[k]) send_byte(text_bytes[k]);
         send_end();
         if ($urandom_range(0, 7) == 0) wait_drained();
      end

      // Closing text with a number, a keyword and punctuators.
      send_text("x+12 return;");
      send_end();
      wait_drained();
      repeat (20) @(posedge clock);

      if (lexer_sb.failures == 0 && lexer_sb.pending() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

// ===== files.f =====
design/exlex_pkg.sv
design/exlex_front.sv
design/exlex_queue.sv
design/exlex_back.sv
design/expression_lexer_core.sv
design/exlex_checker.sv
tb/sv/testbench.sv
